[hw/rtl/tvhts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvhts_pkg - shared types and constants of the three-voice tone synth
// Item formats, sine table geometry, the quarter-wave table builder and the
// constants of the final scale by 1/3.75.
// ----------------------------------------------------------------------------
package tvhts_pkg;

  localparam int unsigned STEP_BITS       = 24;
  localparam int unsigned SAMPLE_BITS     = 16;
  localparam int unsigned SINE_INDEX_BITS = 10;
  localparam int unsigned QUARTER_BITS    = SINE_INDEX_BITS - 2;
  localparam int unsigned QUARTER         = 1 << QUARTER_BITS;
  localparam int unsigned ROM_BITS        = 15;
  localparam int unsigned VOICES          = 3;
  localparam int unsigned HARMONICS       = 3;
  localparam int unsigned TAPS            = VOICES * HARMONICS;

  // Mixed sum of nine weighted taps stays below 7 * 3 * 2^15 in magnitude.
  localparam int unsigned SUM_BITS        = 21;
  localparam int unsigned MAG_BITS        = SUM_BITS - 1;

  // Divide by 15 as multiply by ceil(2^28 / 15) and shift; exact below 2^20.
  localparam int unsigned DIV_SHIFT       = 28;
  localparam int unsigned DIV_MUL_BITS    = 25;
  localparam logic [DIV_MUL_BITS-1:0] DIV_MUL = 25'd17895698;
  localparam logic [MAG_BITS-1:0]     DIV_ROUND = 20'd7;
  localparam int unsigned PROD_BITS       = MAG_BITS + DIV_MUL_BITS;
  localparam int unsigned QUOT_BITS       = PROD_BITS - DIV_SHIFT;

  localparam logic [63:0] COEF1 = 64'd1686629713;
  localparam logic [63:0] COEF3 = 64'd693598668;
  localparam logic [63:0] COEF5 = 64'd85569306;
  localparam logic [63:0] COEF7 = 64'd5026995;
  localparam logic [63:0] COEF9 = 64'd172272;

  typedef struct packed {
    logic [STEP_BITS-1:0] voice_one_step;
    logic [STEP_BITS-1:0] voice_two_step;
    logic [STEP_BITS-1:0] voice_three_step;
    logic                 end_of_block;
  } tvhts_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mixed_sample;
    logic                          last_in_block;
  } tvhts_out_t;

  // One folded sine lookup: table address and sign of the half wave.
  typedef struct packed {
    logic                  negate;
    logic [QUARTER_BITS:0] addr;
  } tvhts_tap_t;

  // One classified sample tick handed from front to back.
  typedef struct packed {
    tvhts_tap_t [TAPS-1:0] taps;
    logic                  end_of_block;
  } tvhts_job_t;

  function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] prod;
    prod = a * b + (64'd1 << 29);
    return prod >> 30;
  endfunction

  // Quarter-wave entry k: odd degree-9 polynomial of sin(pi/2 * k/QUARTER).
  function automatic logic [ROM_BITS-1:0] sine_entry(input int unsigned k);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] p;
    logic [63:0] v;
    z  = 64'(k) << (30 - QUARTER_BITS);
    z2 = mul_q30(z, z);
    p  = COEF7 - mul_q30(z2, COEF9);
    p  = COEF5 - mul_q30(z2, p);
    p  = COEF3 - mul_q30(z2, p);
    p  = COEF1 - mul_q30(z2, p);
    v  = (mul_q30(z, p) + (64'd1 << 14)) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[ROM_BITS-1:0];
  endfunction

endpackage

[hw/rtl/tvhts_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvhts_front - phase accumulators and lookup classification
// Forms the 1x, 2x and 3x angles of each voice from the current phases,
// folds each into a quarter-wave address and sign, and advances the phases.
// ----------------------------------------------------------------------------
module tvhts_front import tvhts_pkg::*; #(
  parameter int unsigned PHASE_BITS = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tvhts_in_t  item_i,
  input  logic       accept_i,
  output tvhts_job_t job_o
);

  logic [PHASE_BITS-1:0] phase_q [VOICES];
  logic [PHASE_BITS-1:0] phase_d [VOICES];
  logic [STEP_BITS-1:0]  step_raw [VOICES];
  logic [PHASE_BITS-1:0] step [VOICES];

  assign step_raw[0] = item_i.voice_one_step;
  assign step_raw[1] = item_i.voice_two_step;
  assign step_raw[2] = item_i.voice_three_step;

  for (genvar v = 0; v < VOICES; v++) begin : g_voice
    logic [PHASE_BITS-1:0] angle [HARMONICS];

    if (PHASE_BITS > STEP_BITS) begin : g_wide
      assign step[v] = {{(PHASE_BITS - STEP_BITS){1'b0}}, step_raw[v]};
    end else begin : g_narrow
      assign step[v] = step_raw[v][PHASE_BITS-1:0];
    end

    // Angles wrap modulo one cycle by dropping the carry.
    assign angle[0] = phase_q[v];
    assign angle[1] = phase_q[v] << 1;
    assign angle[2] = phase_q[v] + (phase_q[v] << 1);

    for (genvar h = 0; h < HARMONICS; h++) begin : g_harm
      logic [SINE_INDEX_BITS-1:0] idx;
      logic [QUARTER_BITS-1:0]    k;

      assign idx = angle[h][PHASE_BITS-1 -: SINE_INDEX_BITS];
      assign k   = idx[QUARTER_BITS-1:0];
      // Odd quadrants read the mirrored entry, the upper half wave negates.
      assign job_o.taps[v*HARMONICS+h].negate = idx[SINE_INDEX_BITS-1];
      assign job_o.taps[v*HARMONICS+h].addr   = idx[SINE_INDEX_BITS-2] ?
          ((QUARTER_BITS+1)'(QUARTER) - {1'b0, k}) : {1'b0, k};
    end

    assign phase_d[v] = accept_i ? (phase_q[v] + step[v]) : phase_q[v];
  end

  assign job_o.end_of_block = item_i.end_of_block;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VOICES; i++) begin
        phase_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < VOICES; i++) begin
        phase_q[i] <= phase_d[i];
      end
    end
  end

endmodule

[hw/rtl/tvhts_job_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvhts_job_queue - two-entry queue between front and back
// Lets the front keep accepting while the back holds, and vice versa.
// ----------------------------------------------------------------------------
module tvhts_job_queue import tvhts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_i,
  input  tvhts_job_t wr_job_i,
  output logic       full_o,
  input  logic       rd_i,
  output tvhts_job_t rd_job_o,
  output logic       valid_o
);

  tvhts_job_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q,  count_d;
  logic       do_wr, do_rd;

  assign full_o   = (count_q == 2'd2);
  assign valid_o  = (count_q != 2'd0);
  assign rd_job_o = entry_q[rd_ptr_q];
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && valid_o;

  always_comb begin
    wr_ptr_d = do_wr ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_rd ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wr_ptr_q] <= wr_job_i;
    end
  end

endmodule

[hw/rtl/tvhts_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvhts_back - sine lookup, mixing, scaling and result queue
// Three-stage pipeline (lookup, sum, scale multiply), then saturation into an
// eight-entry result queue. Issue is credit based so the queue never overflows.
// ----------------------------------------------------------------------------
module tvhts_back import tvhts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tvhts_job_t job_i,
  input  logic       job_valid_i,
  output logic       job_take_o,
  output tvhts_out_t result_o,
  output logic       empty_o,
  input  logic       pop_i
);

  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned PTR_BITS  = $clog2(OUT_DEPTH);
  localparam int unsigned CNT_BITS  = PTR_BITS + 1;

  // Quarter-wave table, fixed at elaboration.
  logic [ROM_BITS-1:0] sine_rom [QUARTER+1];
  for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
    assign sine_rom[k] = sine_entry(k);
  end

  // Stage 1: signed lookups.
  logic                          s1_valid_q;
  logic signed [SAMPLE_BITS-1:0] s1_tap_q [TAPS];
  logic                          s1_eob_q;
  // Stage 2: mixed sum.
  logic                          s2_valid_q;
  logic signed [SUM_BITS-1:0]    s2_sum_q;
  logic                          s2_eob_q;
  // Stage 3: scaled magnitude.
  logic                          s3_valid_q;
  logic [PROD_BITS-1:0]          s3_prod_q;
  logic                          s3_neg_q;
  logic                          s3_eob_q;

  logic signed [SUM_BITS-1:0]    sum_d;
  logic [MAG_BITS-1:0]           mag;
  logic [MAG_BITS-1:0]           num;
  logic [QUOT_BITS-1:0]          quot;
  logic [SAMPLE_BITS-1:0]        sample;

  tvhts_out_t           out_q [OUT_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0]  count_q,  count_d;
  logic [CNT_BITS-1:0]  committed;
  logic                 do_pop;

  // Hold issue unless the queue has room for everything already in flight.
  assign committed  = count_q + CNT_BITS'(s1_valid_q) + CNT_BITS'(s2_valid_q)
                    + CNT_BITS'(s3_valid_q);
  assign job_take_o = job_valid_i && (committed < CNT_BITS'(OUT_DEPTH));

  always_comb begin
    sum_d = '0;
    for (int v = 0; v < VOICES; v++) begin
      sum_d = sum_d
            + (SUM_BITS'(s1_tap_q[v*HARMONICS])   <<< 2)
            + (SUM_BITS'(s1_tap_q[v*HARMONICS+1]) <<< 1)
            +  SUM_BITS'(s1_tap_q[v*HARMONICS+2]);
    end
  end

  assign mag = s2_sum_q[SUM_BITS-1] ? MAG_BITS'(-s2_sum_q) : MAG_BITS'(s2_sum_q);
  assign num = mag + DIV_ROUND;

  // Round-to-nearest quotient, saturate, restore the sign.
  always_comb begin
    quot = s3_prod_q[PROD_BITS-1:DIV_SHIFT];
    if (s3_neg_q) begin
      if (quot > QUOT_BITS'(1 << (SAMPLE_BITS - 1))) begin
        quot = QUOT_BITS'(1 << (SAMPLE_BITS - 1));
      end
      sample = SAMPLE_BITS'(-quot);
    end else begin
      if (quot > QUOT_BITS'((1 << (SAMPLE_BITS - 1)) - 1)) begin
        quot = QUOT_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
      end
      sample = SAMPLE_BITS'(quot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= job_take_o;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int t = 0; t < TAPS; t++) begin
      s1_tap_q[t] <= job_i.taps[t].negate
          ? -$signed({1'b0, sine_rom[job_i.taps[t].addr]})
          :  $signed({1'b0, sine_rom[job_i.taps[t].addr]});
    end
    s1_eob_q  <= job_i.end_of_block;
    s2_sum_q  <= sum_d;
    s2_eob_q  <= s1_eob_q;
    s3_prod_q <= PROD_BITS'(num) * PROD_BITS'(DIV_MUL);
    s3_neg_q  <= s2_sum_q[SUM_BITS-1];
    s3_eob_q  <= s2_eob_q;
  end

  // Result queue.
  assign empty_o  = (count_q == '0);
  assign result_o = out_q[rd_ptr_q];
  assign do_pop   = pop_i && !empty_o;
  assign count_d  = count_q + CNT_BITS'(s3_valid_q) - CNT_BITS'(do_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (s3_valid_q) begin
        wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_valid_q) begin
      out_q[wr_ptr_q].mixed_sample  <= $signed(sample);
      out_q[wr_ptr_q].last_in_block <= s3_eob_q;
    end
  end

endmodule

[hw/rtl/three_voice_harmonic_tone_synth.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_voice_harmonic_tone_synth - three-voice additive sine synthesizer
// Each item is one sample tick carrying three phase steps. Each voice adds
// sines at 1x, 2x and 3x its phase weighted 1, 1/2, 1/4; the mix is scaled
// by 1/3.75, rounded and saturated to a signed Q1.15 sample.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake          payload
//   -------   ---------  -----------------  ------------------------------
//   item      in         push / full        item_i   (tvhts_in_t)
//   result    out        empty / pop        result_o (tvhts_out_t)
//
// Throughput is one item per cycle unless the result queue backs up, set by
// the phase update in the front and the fully pipelined back. An accepted
// item passes the job queue, lookup, sum, scale multiply and result queue.
// Reset clears the phases and empties both queues; the sine table is
// constant, so the block takes items right after reset.
// With pop held low the eight-entry result queue fills, the back stops
// issuing, the two-entry job queue fills and full rises.
//
module three_voice_harmonic_tone_synth import tvhts_pkg::*; #(
  parameter int unsigned PHASE_BITS = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  tvhts_in_t  item_i,
  output logic       empty,
  input  logic       pop,
  output tvhts_out_t result_o
);

  tvhts_job_t front_job;
  tvhts_job_t back_job;
  logic       job_valid;
  logic       job_take;
  logic       accept;

  // Advance the phases only on an accepted item.
  assign accept = push && !full;

  tvhts_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .accept_i (accept),
    .job_o    (front_job)
  );

  // Decouple the front from back-pressure on the result side.
  tvhts_job_queue u_job_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (push),
    .wr_job_i (front_job),
    .full_o   (full),
    .rd_i     (job_take),
    .rd_job_o (back_job),
    .valid_o  (job_valid)
  );

  tvhts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (back_job),
    .job_valid_i (job_valid),
    .job_take_o  (job_take),
    .result_o    (result_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule

[tb/sv/three_voice_harmonic_tone_synth_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_voice_harmonic_tone_synth_tb - self-checking bench of the tone synth
// Feeds sample ticks through the push/full side and pops mixed samples from
// the empty/pop side, often with random gaps on both. A local model of the phase
// accumulators, the quarter-wave sine table and the 1/3.75 scale predicts
// every sample; each popped result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module three_voice_harmonic_tone_synth_tb import tvhts_pkg::*; ();

  localparam int unsigned STALL_LIMIT = 1000;  // cycles with no handshake at all
  localparam int unsigned HOLD_CYCLES = 80;    // long receiver hold-off
  localparam int unsigned DRAIN_TAIL  = 12;    // idle tail after the last result

  // Polynomial coefficients of sin(pi/2 * z) in Q30.
  localparam logic [63:0] TAYLOR_C1 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_C3 = 64'd693598668;
  localparam logic [63:0] TAYLOR_C5 = 64'd85569306;
  localparam logic [63:0] TAYLOR_C7 = 64'd5026995;
  localparam logic [63:0] TAYLOR_C9 = 64'd172272;

  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  tvhts_in_t  item_i;
  logic       empty;
  logic       pop;
  tvhts_out_t result_o;

  three_voice_harmonic_tone_synth DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  // Model state: quarter-wave table and the three voice phases.
  int                   sine_quarter [QUARTER+1];
  logic [STEP_BITS-1:0] voice_phase  [VOICES];

  // Samples predicted but not yet popped, oldest first.
  tvhts_out_t expected_samples[$];

  // Knobs shared by the stimulus and the receiver.
  bit sender_gaps_on;
  bit receiver_gaps_on;
  bit hold_request;
  int unsigned hold_left;

  // Bookkeeping.
  int unsigned error_count;
  int unsigned ticks_sent;
  int unsigned samples_checked;
  int unsigned clipped_seen;
  int unsigned blocks_closed;
  int unsigned full_stalls;
  int unsigned quiet_cycles;

  // --------------------------------------------------------------------------
  // Clock: 8 ns period.
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever begin
      #4 clk_i = ~clk_i;
    end
  end

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------

  // Q30 product, rounded half up.
  function automatic logic [63:0] q30_product(input logic [63:0] a, input logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // Fill the quarter-wave table: Horner form of the odd degree-9 polynomial.
  task automatic build_sine_quarter();
    logic [63:0] z;
    logic [63:0] zz;
    logic [63:0] acc;
    logic [63:0] val;
    for (int k = 0; k <= QUARTER; k++) begin
      z   = 64'(k) << (30 - QUARTER_BITS);
      zz  = q30_product(z, z);
      acc = TAYLOR_C7 - q30_product(zz, TAYLOR_C9);
      acc = TAYLOR_C5 - q30_product(zz, acc);
      acc = TAYLOR_C3 - q30_product(zz, acc);
      acc = TAYLOR_C1 - q30_product(zz, acc);
      val = (q30_product(z, acc) + (64'd1 << 14)) >> 15;
      sine_quarter[k] = (val > 64'd32767) ? 32767 : int'(val);
    end
  endtask

  // Fold one angle onto the quarter wave: mirror odd quadrants, negate the
  // upper half wave.
  function automatic int sine_at(input logic [STEP_BITS-1:0] angle);
    logic [SINE_INDEX_BITS-1:0] idx;
    int unsigned                k;
    int                         v;
    idx = angle[STEP_BITS-1 -: SINE_INDEX_BITS];
    k   = 32'(idx[QUARTER_BITS-1:0]);
    v   = idx[QUARTER_BITS] ? sine_quarter[QUARTER - k] : sine_quarter[k];
    return idx[QUARTER_BITS+1] ? -v : v;
  endfunction

  // Fundamental, second and third harmonic in quarter units: 4 : 2 : 1.
  function automatic int harmonic_mix(input logic [STEP_BITS-1:0] ph);
    logic [STEP_BITS-1:0] ph2;
    logic [STEP_BITS-1:0] ph3;
    ph2 = ph + ph;
    ph3 = ph2 + ph;
    return 4 * sine_at(ph) + 2 * sine_at(ph2) + sine_at(ph3);
  endfunction

  // Predict the sample of one tick from the phases as they stand, then
  // advance every phase by its step modulo one cycle.
  task automatic predict_sample(input tvhts_in_t tick);
    tvhts_out_t  smp;
    int          total;
    int unsigned mag;
    int unsigned quot;
    int          value;
    total = harmonic_mix(voice_phase[0]) + harmonic_mix(voice_phase[1])
          + harmonic_mix(voice_phase[2]);
    mag   = (total < 0) ? -total : total;
    quot  = (mag + 7) / 15;
    value = (total < 0) ? -int'(quot) : int'(quot);
    if (value > SAMPLE_MAX) begin
      value = SAMPLE_MAX;
    end else if (value < SAMPLE_MIN) begin
      value = SAMPLE_MIN;
    end
    smp.mixed_sample  = value[SAMPLE_BITS-1:0];
    smp.last_in_block = tick.end_of_block;
    expected_samples.insert(expected_samples.size(), smp);
    voice_phase[0] = voice_phase[0] + tick.voice_one_step;
    voice_phase[1] = voice_phase[1] + tick.voice_two_step;
    voice_phase[2] = voice_phase[2] + tick.voice_three_step;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: pop with random gaps when enabled; honor a long hold-off when asked.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        pop <= 1'b0;
      end else if (receiver_gaps_on) begin
        pop <= ($urandom_range(0, 99) >= 21);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check: compare every popped sample with the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    tvhts_out_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_samples.size() == 0) begin
        $display("%0t unexpected sample, expected none, actual %0d / %0b", $time,
                 result_o.mixed_sample, result_o.last_in_block);
        error_count++;
      end else begin
        want = expected_samples.pop_front();
        samples_checked++;
        if (result_o.mixed_sample != want.mixed_sample) begin
          $display("%0t mixed_sample mismatch, expected %0d, actual %0d", $time,
                   want.mixed_sample, result_o.mixed_sample);
          error_count++;
        end
        if (result_o.last_in_block != want.last_in_block) begin
          $display("%0t last_in_block mismatch, expected %0b, actual %0b", $time,
                   want.last_in_block, result_o.last_in_block);
          error_count++;
        end
        if (want.mixed_sample == 16'sh7fff || want.mixed_sample == 16'sh8000) begin
          clipped_seen++;
        end
        if (want.last_in_block) begin
          blocks_closed++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when neither side moves for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic tvhts_in_t make_tick(input logic [STEP_BITS-1:0] s1,
                                          input logic [STEP_BITS-1:0] s2,
                                          input logic [STEP_BITS-1:0] s3,
                                          input logic eob);
    tvhts_in_t t;
    t.voice_one_step   = s1;
    t.voice_two_step   = s2;
    t.voice_three_step = s3;
    t.end_of_block     = eob;
    return t;
  endfunction

  // Offer one tick and hold it until accepted. Push stays high afterwards so
  // back-to-back ticks keep it asserted; only idling lowers it.
  task automatic send_tick(input tvhts_in_t tick);
    while (sender_gaps_on && $urandom_range(0, 99) < 21) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push   <= 1'b1;
    item_i <= tick;
    @(posedge clk_i);
    while (full) begin
      full_stalls++;
      @(posedge clk_i);
    end
    predict_sample(tick);
    ticks_sent++;
  endtask

  // Mostly audio-range steps, plus wide random ones and the quadrant points.
  function automatic logic [STEP_BITS-1:0] pick_step();
    logic [STEP_BITS-1:0] s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: s = STEP_BITS'($urandom_range(1, 24'h00ffff));
      4, 5, 6:    s = STEP_BITS'($urandom);
      7: begin
        case ($urandom_range(0, 5))
          0:       s = '0;
          1:       s = '1;
          2:       s = 24'h400000;
          3:       s = 24'h800000;
          4:       s = 24'hc00000;
          default: s = 24'h200000;
        endcase
      end
      8:       s = {2'($urandom_range(0, 3)), 22'h0}
                 + STEP_BITS'($urandom_range(0, 31)) - 24'd16;
      default: s = STEP_BITS'($urandom_range(24'h0f0000, 24'h7fffff));
    endcase
    return s;
  endfunction

  // One output buffer: steady tones with an occasional retune, the flag on
  // the last tick, and now and then a misplaced flag.
  task automatic play_block(input int unsigned len);
    logic [STEP_BITS-1:0] s1;
    logic [STEP_BITS-1:0] s2;
    logic [STEP_BITS-1:0] s3;
    logic                 eob;
    s1 = pick_step();
    s2 = ($urandom_range(0, 7) == 0) ? s1 : pick_step();
    s3 = pick_step();
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        s1 = pick_step();
      end
      if ($urandom_range(0, 19) == 0) begin
        s3 = pick_step();
      end
      eob = (i == len - 1);
      if ($urandom_range(0, 29) == 0) begin
        eob = ~eob;
      end
      send_tick(make_tick(s1, s2, s3, eob));
    end
  endtask

  task automatic wait_all_results();
    while (expected_samples.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Zero and full-scale steps, phase wrap, quadrant edges and both clip rails.
  task automatic test_directed();
    sender_gaps_on   = 1'b1;
    receiver_gaps_on = 1'b1;
    // Phases start at zero: silent sample.
    send_tick(make_tick(24'h000000, 24'h000000, 24'h000000, 1'b0));
    // Move all voices to 1/8 cycle: clip high.
    send_tick(make_tick(24'h200000, 24'h200000, 24'h200000, 1'b1));
    send_tick(make_tick(24'h000000, 24'h000000, 24'h000000, 1'b0));
    // Three quarters of a cycle on to 7/8: clip low.
    send_tick(make_tick(24'hc00000, 24'hc00000, 24'hc00000, 1'b0));
    send_tick(make_tick(24'h000000, 24'h000000, 24'h000000, 1'b1));
    // Full-scale steps wrap every phase back by one LSB.
    send_tick(make_tick(24'hffffff, 24'hffffff, 24'hffffff, 1'b0));
    send_tick(make_tick(24'hffffff, 24'h000001, 24'h800000, 1'b1));
    // Walk the quadrant boundaries.
    send_tick(make_tick(24'h7fffff, 24'h3fffff, 24'hbfffff, 1'b0));
    send_tick(make_tick(24'h000001, 24'h000001, 24'h000001, 1'b0));
    send_tick(make_tick(24'h400000, 24'hc00000, 24'h400000, 1'b0));
    send_tick(make_tick(24'hc00000, 24'h400000, 24'h800000, 1'b1));
    // Alternating bit patterns on every step field.
    send_tick(make_tick(24'haaaaaa, 24'h555555, 24'haaaaaa, 1'b0));
    send_tick(make_tick(24'h555555, 24'haaaaaa, 24'h555555, 1'b1));
    // Sub-index steps: phase moves below the table resolution.
    send_tick(make_tick(24'h003fff, 24'h000100, 24'h002000, 1'b0));
    send_tick(make_tick(24'h004000, 24'h003fff, 24'h000001, 1'b0));
    send_tick(make_tick(24'h000000, 24'h000000, 24'h000000, 1'b1));
  endtask

  task automatic test_random_tones(input int unsigned n);
    int unsigned target;
    sender_gaps_on   = 1'b1;
    receiver_gaps_on = 1'b1;
    target = ticks_sent + n;
    while (ticks_sent < target) begin
      play_block($urandom_range(1, 32));
    end
  endtask

  // Both sides flat out: one tick in and one sample out every cycle unless full.
  task automatic test_full_rate(input int unsigned n);
    int unsigned target;
    sender_gaps_on   = 1'b0;
    receiver_gaps_on = 1'b0;
    target = ticks_sent + n;
    while (ticks_sent < target) begin
      play_block($urandom_range(8, 48));
    end
  endtask

  // Receiver holds off while the sender keeps offering: fill up and stall.
  task automatic test_backpressure(input int unsigned n);
    int unsigned target;
    sender_gaps_on   = 1'b0;
    receiver_gaps_on = 1'b1;
    hold_request     = 1'b1;
    target = ticks_sent + n;
    while (ticks_sent < target) begin
      play_block($urandom_range(4, 16));
    end
  endtask

  // Sender pauses until the block is empty, then resumes with random ticks.
  task automatic test_pause_and_resume(input int unsigned n);
    push <= 1'b0;
    @(posedge clk_i);
    wait_all_results();
    test_random_tones(n);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    push             = 1'b0;
    item_i           = '0;
    rst_ni           = 1'b0;
    sender_gaps_on   = 1'b0;
    receiver_gaps_on = 1'b0;
    hold_request     = 1'b0;
    hold_left        = 0;
    error_count      = 0;
    ticks_sent       = 0;
    samples_checked  = 0;
    clipped_seen     = 0;
    blocks_closed    = 0;
    full_stalls      = 0;
    quiet_cycles     = 0;
    for (int v = 0; v < VOICES; v++) begin
      voice_phase[v] = '0;
    end
    build_sine_quarter();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_tones(900);
    test_full_rate(300);
    test_backpressure(80);
    test_pause_and_resume(600);

    push <= 1'b0;
    @(posedge clk_i);
    wait_all_results();
    repeat (DRAIN_TAIL) @(posedge clk_i);

    $display("run: %0d ticks in, %0d samples checked, %0d blocks closed",
             ticks_sent, samples_checked, blocks_closed);
    $display("run: %0d clipped samples, %0d cycles with full raised against push",
             clipped_seen, full_stalls);
    if (error_count == 0 && expected_samples.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
